// ===== hw/rtl/gcc_pkg.sv =====
// Shared types, constants and saturating helpers for the gripper compliance controller.
package gcc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;
    localparam int ADDR_W    = 5;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [2:0] t_reg_idx;

    localparam t_word SMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word SMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word ONE  = t_word'(64'd1 << FRAC_BITS);
    localparam t_word XMAX = t_word'(64'd55 << FRAC_BITS);
    localparam t_word LIMIT = t_word'(64'd2000 << FRAC_BITS);
    localparam t_word CUR_OFFSET = 32'sd318;
    localparam t_word CUR_SCALE  = t_word'(5 * (64'd1 << (FRAC_BITS - 2)));
    localparam logic [23:0] MV_GAIN = 24'd3300;
    localparam logic [12:0] T_RESET = 13'd6554;

    // function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_START = 2'd1;
    localparam logic [1:0] FUNC_STOP  = 2'd2;

    // control modes
    localparam logic [2:0] MODE_POS = 3'd1;
    localparam logic [2:0] MODE_ADM = 3'd2;
    localparam logic [2:0] MODE_IMP = 3'd3;
    localparam logic [2:0] MODE_STF = 3'd4;
    localparam logic [2:0] MODE_DMP = 3'd5;
    localparam logic [2:0] MODE_PAR = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_STARTED = 3'd1;
    localparam logic [2:0] ST_USER    = 3'd2;
    localparam logic [2:0] ST_FORCE   = 3'd3;
    localparam logic [2:0] ST_CURRENT = 3'd4;
    localparam logic [2:0] ST_BADMODE = 3'd5;

    // register indexes
    localparam t_reg_idx REG_MODE = 3'd0;
    localparam t_reg_idx REG_FD   = 3'd1;
    localparam t_reg_idx REG_XD   = 3'd2;
    localparam t_reg_idx REG_VD   = 3'd3;
    localparam t_reg_idx REG_M    = 3'd4;
    localparam t_reg_idx REG_B    = 3'd5;
    localparam t_reg_idx REG_K    = 3'd6;
    localparam t_reg_idx REG_T    = 3'd7;

    typedef struct packed {
        logic  start;
        logic  is_div;
        t_word a;
        t_word b;
    } t_mdu_req;

    typedef struct packed {
        logic  done;
        t_word res;
    } t_mdu_rsp;

    function automatic t_word sat_add(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? SMIN : SMAX;
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic t_word sat_sub(input t_word a, input t_word b);
        logic signed [WORD_BITS:0] s;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1]) begin
            return s[WORD_BITS] ? SMIN : SMAX;
        end
        return s[WORD_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/gcc_if.sv =====
// Valid/ready channel interfaces for the sample items and the result items.
interface gcc_in_if import gcc_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [11:0] force_a;
    logic [11:0] force_b;
    logic [21:0] jaw_opening;
    logic [11:0] current_sample;

    modport source (output valid, func, force_a, force_b, jaw_opening, current_sample,
                    input ready);
    modport sink (input valid, func, force_a, force_b, jaw_opening, current_sample,
                  output ready);
endinterface

interface gcc_out_if import gcc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [21:0]        setpoint_opening;
    logic               running;
    logic [2:0]         status_code;
    logic [27:0]        force_smoothed;
    logic [21:0]        opening_smoothed;
    logic signed [31:0] velocity_smoothed;
    logic signed [29:0] current_smoothed;

    modport source (output valid, setpoint_opening, running, status_code, force_smoothed,
                    opening_smoothed, velocity_smoothed, current_smoothed,
                    input ready);
    modport sink (input valid, setpoint_opening, running, status_code, force_smoothed,
                  opening_smoothed, velocity_smoothed, current_smoothed,
                  output ready);
endinterface

// ===== hw/rtl/gcc_mdu.sv =====
// Shared fixed-point multiply / bit-serial divide unit with saturation.
module gcc_mdu import gcc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mdu_req i_req,
    output t_mdu_rsp o_rsp
);

    typedef enum logic [2:0] {U_IDLE, U_MUL, U_MSAT, U_DIV, U_FIN} t_ustate;

    t_ustate                 r_state;
    logic                    r_neg;
    logic                    r_ovf;
    logic [WORD_BITS-1:0]    r_x;
    logic [WORD_BITS-1:0]    r_y;
    logic [2*WORD_BITS-1:0]  r_prod;
    logic [WORD_BITS-1:0]    r_rem;
    logic [DIV_BITS-1:0]     r_q;
    logic [5:0]              r_cnt;

    logic [WORD_BITS-1:0] mag_a, mag_b;
    logic [WORD_BITS:0]   trial, diff;
    logic                 ge;
    logic [DIV_BITS-1:0]  lim, m;

    assign mag_a = i_req.a[WORD_BITS-1] ? (WORD_BITS'(0) - i_req.a) : i_req.a;
    assign mag_b = i_req.b[WORD_BITS-1] ? (WORD_BITS'(0) - i_req.b) : i_req.b;
    assign trial = {r_rem, r_q[DIV_BITS-1]};
    assign diff  = trial - {1'b0, r_y};
    assign ge    = (trial >= {1'b0, r_y});

    // magnitude limit: 2^31 for negative results, 2^31-1 otherwise
    assign lim = {{FRAC_BITS{1'b0}}, r_neg, {(WORD_BITS-1){~r_neg}}};
    assign m   = (r_ovf || (r_q > lim)) ? lim : r_q;

    assign o_rsp.done = (r_state == U_FIN);
    assign o_rsp.res  = r_neg ? t_word'(WORD_BITS'(0) - m[WORD_BITS-1:0])
                              : t_word'(m[WORD_BITS-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            case (r_state)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_ovf <= 1'b0;
                        r_y   <= mag_b;
                        r_x   <= mag_a;
                        if (!i_req.is_div) begin
                            r_neg   <= i_req.a[WORD_BITS-1] ^ i_req.b[WORD_BITS-1];
                            r_state <= U_MUL;
                        end else if (mag_b == '0) begin
                            // divide by zero saturates toward the numerator's sign
                            r_neg   <= i_req.a[WORD_BITS-1];
                            r_ovf   <= (i_req.a != '0);
                            r_q     <= '0;
                            r_state <= U_FIN;
                        end else begin
                            r_neg   <= i_req.a[WORD_BITS-1] ^ i_req.b[WORD_BITS-1];
                            r_q     <= {mag_a, {FRAC_BITS{1'b0}}};
                            r_state <= U_DIV;
                        end
                    end
                end
                U_MUL: begin
                    r_prod  <= r_x * r_y;
                    r_state <= U_MSAT;
                end
                U_MSAT: begin
                    r_q     <= {{FRAC_BITS{1'b0}}, r_prod[WORD_BITS+FRAC_BITS-1:FRAC_BITS]};
                    r_ovf   <= |r_prod[2*WORD_BITS-1:WORD_BITS+FRAC_BITS];
                    r_state <= U_FIN;
                end
                U_DIV: begin
                    r_rem <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
                    r_q   <= {r_q[DIV_BITS-2:0], ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'(DIV_BITS - 1)) begin
                        r_state <= U_FIN;
                    end
                end
                U_FIN: begin
                    r_state <= U_IDLE;
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/gripper_compliance_controller.sv =====
// Gripper compliance controller: a sample tick (func 0) filters two force readings, the jaw
// opening and the servo current, derives velocity, checks the 2000 g / 2000 mA limits and,
// while running, updates the jaw setpoint in the selected mode; func 1 starts and func 2
// stops regulation. The filter and control-law products and quotients run through one
// shared multiply/divide unit under a sequencer, one item at a time (48-bit bit-serial
// quotient for a divide).
// A finished result waits in the output register while the next item is taken.
// Registers sit on the APB port at byte address 4*index and may be written while idle.
module gripper_compliance_controller import gcc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gcc_in_if.sink            i_in,
    gcc_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [4:0] {
        S_IDLE, S_F1, S_F2, S_O1, S_O2, S_VD, S_V1, S_V2, S_C1, S_C2, S_CHK,
        S_MT, S_KT, S_A1, S_A2, S_A3, S_A4, S_M4, S_M5, S_M6A, S_M6B, S_M6C,
        S_CV, S_CLAMP, S_DONE
    } t_state;

    t_state r_state;
    logic   r_wait;

    // configuration
    logic [2:0]  r_mode;
    logic [26:0] r_fd;
    logic [21:0] r_xd;
    logic [23:0] r_vd;
    logic [25:0] r_m, r_b, r_k;
    logic [12:0] r_t;

    // controller state
    t_word r_ff, r_of, r_op, r_vf, r_cf, r_cmd, r_cv, r_a1, r_a2, r_a3;
    logic  r_active;
    logic [2:0] r_status;

    // scratch
    t_word r_p, r_x, r_mt, r_kt, r_den;
    logic [11:0] r_fa, r_fb, r_code;
    logic [21:0] r_jaw;

    // output register
    logic               r_ovalid;
    logic [21:0]        r_osp;
    logic               r_orun;
    logic [2:0]         r_ost;
    logic [27:0]        r_off;
    logic [21:0]        r_oof;
    logic signed [31:0] r_ovf;
    logic signed [29:0] r_ocf;

    t_mdu_req u_req;
    t_mdu_rsp u_rsp;

    t_word w1, w2, force_in, jaw_in, cur_in, mvd;
    t_word fd_w, xd_w, vd_w, m_w, b_w, k_w, t_w, a1n;
    logic [16:0] w10, w1n;
    logic [12:0] fsum;
    logic [23:0] mvp;
    logic        accept, cfg_wr, op_state, adm, do_halt;
    logic [2:0]  halt_code;
    t_reg_idx    cfg_idx;

    gcc_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .o_rsp   (u_rsp)
    );

    assign accept  = i_in.valid && i_in.ready;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign adm     = (r_mode == MODE_ADM);

    assign fd_w = t_word'({5'b0, r_fd});
    assign xd_w = t_word'({10'b0, r_xd});
    assign vd_w = t_word'({{8{r_vd[23]}}, r_vd});
    assign m_w  = t_word'({6'b0, r_m});
    assign b_w  = t_word'({6'b0, r_b});
    assign k_w  = t_word'({6'b0, r_k});
    assign t_w  = t_word'({19'b0, r_t});

    // filter weights: w1 = min(10*T, 1), w2 = 1 - w1
    assign w10 = 17'(r_t) * 17'd10;
    assign w1n = (w10 > 17'(ONE)) ? 17'(ONE) : w10;
    assign w1  = t_word'({15'b0, w1n});
    assign w2  = ONE - w1;

    assign fsum     = {1'b0, r_fa} + {1'b0, r_fb};
    assign force_in = t_word'({4'b0, fsum, 15'b0});
    assign jaw_in   = t_word'({10'b0, r_jaw});
    assign mvp      = 24'(r_code) * MV_GAIN;
    assign mvd      = t_word'({20'b0, mvp[23:12]}) - CUR_OFFSET;
    assign cur_in   = mvd * CUR_SCALE;
    assign a1n      = sat_add(r_a1, u_rsp.res);

    always_comb begin
        case (cfg_idx)
            REG_MODE: prdata = {29'b0, r_mode};
            REG_FD:   prdata = {5'b0, r_fd};
            REG_XD:   prdata = {10'b0, r_xd};
            REG_VD:   prdata = {8'b0, r_vd};
            REG_M:    prdata = {6'b0, r_m};
            REG_B:    prdata = {6'b0, r_b};
            REG_K:    prdata = {6'b0, r_k};
            REG_T:    prdata = {19'b0, r_t};
            default:  prdata = '0;
        endcase
    end

    // operand selection for the shared unit
    always_comb begin
        op_state     = 1'b1;
        u_req.is_div = 1'b0;
        u_req.a      = '0;
        u_req.b      = '0;
        case (r_state)
            S_F1:  begin u_req.a = w1;   u_req.b = force_in; end
            S_F2:  begin u_req.a = w2;   u_req.b = r_ff;     end
            S_O1:  begin u_req.a = w1;   u_req.b = jaw_in;   end
            S_O2:  begin u_req.a = w2;   u_req.b = r_of;     end
            S_VD:  begin u_req.is_div = 1'b1; u_req.a = sat_sub(r_of, r_op); u_req.b = t_w; end
            S_V1:  begin u_req.a = w1;   u_req.b = r_x;      end
            S_V2:  begin u_req.a = w2;   u_req.b = r_vf;     end
            S_C1:  begin u_req.a = w1;   u_req.b = cur_in;   end
            S_C2:  begin u_req.a = w2;   u_req.b = r_cf;     end
            S_MT:  begin u_req.is_div = 1'b1; u_req.a = m_w; u_req.b = t_w; end
            S_KT:  begin u_req.a = k_w;  u_req.b = t_w;      end
            S_A1:  begin u_req.a = r_kt; u_req.b = adm ? r_a1 : r_a3; end
            S_A2:  begin u_req.a = r_mt; u_req.b = adm ? r_cv : r_a2; end
            S_A3:  begin u_req.is_div = 1'b1; u_req.a = r_x; u_req.b = r_den; end
            S_A4:  begin u_req.a = r_a2; u_req.b = t_w;      end
            S_M4:  begin u_req.is_div = 1'b1; u_req.a = r_ff; u_req.b = k_w; end
            S_M5, S_M6C: begin u_req.is_div = 1'b1; u_req.a = r_ff; u_req.b = b_w; end
            S_M6A: begin u_req.a = r_ff; u_req.b = t_w;      end
            S_M6B: begin u_req.a = r_a1; u_req.b = k_w;      end
            S_CV:  begin u_req.a = r_cv; u_req.b = t_w;      end
            default: op_state = 1'b0;
        endcase
        u_req.start = op_state && !r_wait;
    end

    // stop requests: user stop, limit trip, bad mode
    always_comb begin
        do_halt   = 1'b0;
        halt_code = ST_OK;
        if (r_state == S_IDLE && accept && i_in.func == FUNC_STOP) begin
            do_halt   = 1'b1;
            halt_code = ST_USER;
        end else if (r_state == S_CHK) begin
            if (r_cf > LIMIT) begin
                do_halt   = 1'b1;
                halt_code = ST_CURRENT;
            end else if (r_ff > LIMIT) begin
                do_halt   = 1'b1;
                halt_code = ST_FORCE;
            end else if (r_active && !(r_mode inside {[MODE_POS:MODE_PAR]})) begin
                do_halt   = 1'b1;
                halt_code = ST_BADMODE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
            r_mode   <= '0;
            r_fd     <= '0;
            r_xd     <= XMAX[21:0];
            r_vd     <= '0;
            r_m      <= '0;
            r_b      <= '0;
            r_k      <= '0;
            r_t      <= T_RESET;
            r_ff     <= '0;
            r_of     <= XMAX;
            r_op     <= XMAX;
            r_vf     <= '0;
            r_cf     <= '0;
            r_cmd    <= XMAX;
            r_cv     <= '0;
            r_a1     <= '0;
            r_a2     <= '0;
            r_a3     <= '0;
            r_active <= 1'b0;
            r_status <= ST_OK;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_MODE: r_mode <= pwdata[2:0];
                    REG_FD:   r_fd   <= pwdata[26:0];
                    REG_XD:   r_xd   <= pwdata[21:0];
                    REG_VD:   r_vd   <= pwdata[23:0];
                    REG_M:    r_m    <= pwdata[25:0];
                    REG_B:    r_b    <= pwdata[25:0];
                    REG_K:    r_k    <= pwdata[25:0];
                    REG_T:    r_t    <= pwdata[12:0];
                    default:  ;
                endcase
            end

            if (u_req.start) begin
                r_wait <= 1'b1;
            end
            if (u_rsp.done) begin
                r_wait <= 1'b0;
            end
            if (o_out.ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_fa   <= i_in.force_a;
                        r_fb   <= i_in.force_b;
                        r_jaw  <= i_in.jaw_opening;
                        r_code <= i_in.current_sample;
                        case (i_in.func)
                            FUNC_TICK: r_state <= S_F1;
                            FUNC_START: begin
                                r_cmd    <= XMAX;
                                r_cv     <= '0;
                                r_a1     <= '0;
                                r_a2     <= '0;
                                r_a3     <= '0;
                                r_active <= 1'b1;
                                r_status <= ST_STARTED;
                                r_state  <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_CHK: begin
                    if (do_halt || !r_active) begin
                        r_state <= S_DONE;
                    end else begin
                        case (r_mode)
                            MODE_POS: begin
                                r_cmd   <= xd_w;
                                r_state <= S_CLAMP;
                            end
                            MODE_ADM, MODE_IMP: r_state <= S_MT;
                            MODE_STF: r_state <= S_M4;
                            MODE_DMP: r_state <= S_M5;
                            MODE_PAR: r_state <= S_M6A;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_CLAMP: begin
                    if (r_cmd > XMAX) begin
                        r_cmd <= XMAX;
                    end else if (r_cmd < 0) begin
                        r_cmd <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_osp    <= r_active ? r_cmd[21:0] : XMAX[21:0];
                        r_orun   <= r_active;
                        r_ost    <= r_status;
                        r_off    <= r_ff[27:0];
                        r_oof    <= r_of[21:0];
                        r_ovf    <= r_vf;
                        r_ocf    <= r_cf[29:0];
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    if (u_rsp.done) begin
                        case (r_state)
                            S_F1: begin r_p <= u_rsp.res; r_state <= S_F2; end
                            S_F2: begin r_ff <= sat_add(r_p, u_rsp.res); r_state <= S_O1; end
                            S_O1: begin r_p <= u_rsp.res; r_state <= S_O2; end
                            S_O2: begin r_of <= sat_add(r_p, u_rsp.res); r_state <= S_VD; end
                            S_VD: begin
                                r_x     <= u_rsp.res;
                                r_op    <= r_of;
                                r_state <= S_V1;
                            end
                            S_V1: begin r_p <= u_rsp.res; r_state <= S_V2; end
                            S_V2: begin r_vf <= sat_add(r_p, u_rsp.res); r_state <= S_C1; end
                            S_C1: begin r_p <= u_rsp.res; r_state <= S_C2; end
                            S_C2: begin r_cf <= sat_add(r_p, u_rsp.res); r_state <= S_CHK; end
                            S_MT: begin r_mt <= u_rsp.res; r_state <= S_KT; end
                            S_KT: begin
                                r_kt  <= u_rsp.res;
                                r_den <= sat_add(sat_add(r_mt, u_rsp.res), b_w);
                                if (adm) begin
                                    r_a1 <= sat_add(r_a1, r_cv);
                                    r_x  <= sat_sub(fd_w, r_ff);
                                end else begin
                                    r_a3 <= sat_add(r_a3, r_a2);
                                    r_x  <= r_ff;
                                end
                                r_state <= S_A1;
                            end
                            S_A1: begin r_x <= sat_sub(r_x, u_rsp.res); r_state <= S_A2; end
                            S_A2: begin r_x <= sat_add(r_x, u_rsp.res); r_state <= S_A3; end
                            S_A3: begin
                                if (adm) begin
                                    r_cv    <= u_rsp.res;
                                    r_state <= S_CV;
                                end else begin
                                    r_a2    <= u_rsp.res;
                                    r_state <= S_A4;
                                end
                            end
                            S_A4: begin
                                r_a1    <= a1n;
                                r_cmd   <= sat_sub(xd_w, a1n);
                                r_state <= S_CLAMP;
                            end
                            S_M4: begin r_cmd <= sat_sub(xd_w, u_rsp.res); r_state <= S_CLAMP; end
                            S_M5: begin r_cv <= sat_sub(vd_w, u_rsp.res); r_state <= S_CV; end
                            S_M6A: begin r_a1 <= a1n; r_state <= S_M6B; end
                            S_M6B: begin r_x <= sat_sub(vd_w, u_rsp.res); r_state <= S_M6C; end
                            S_M6C: begin r_cv <= sat_sub(r_x, u_rsp.res); r_state <= S_CV; end
                            S_CV: begin r_cmd <= sat_add(r_cmd, u_rsp.res); r_state <= S_CLAMP; end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
            endcase

            // a stop restores registers and integrators; filters are kept
            if (do_halt) begin
                r_active <= 1'b0;
                r_status <= halt_code;
                r_mode   <= '0;
                r_fd     <= '0;
                r_xd     <= XMAX[21:0];
                r_vd     <= '0;
                r_m      <= '0;
                r_b      <= '0;
                r_k      <= '0;
                r_t      <= T_RESET;
                r_cmd    <= XMAX;
                r_cv     <= '0;
                r_a1     <= '0;
                r_a2     <= '0;
                r_a3     <= '0;
            end
        end
    end

    assign i_in.ready               = (r_state == S_IDLE);
    assign o_out.valid              = r_ovalid;
    assign o_out.setpoint_opening   = r_osp;
    assign o_out.running            = r_orun;
    assign o_out.status_code        = r_ost;
    assign o_out.force_smoothed     = r_off;
    assign o_out.opening_smoothed   = r_oof;
    assign o_out.velocity_smoothed  = r_ovf;
    assign o_out.current_smoothed   = r_ocf;

    ap_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_rsp.done |-> r_wait)
        else $error("unit finished with no operation pending");

    ap_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_in.ready)
        else $error("input ready right after an accepted item");

    ap_stopped_setpoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.running) |-> (o_out.setpoint_opening == XMAX[21:0]))
        else $error("stopped block reports a setpoint other than full opening");

    ap_cmd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_cmd >= 0 && r_cmd <= XMAX))
        else $error("jaw command out of range at item end");

endmodule

// ===== test/gcc_checker.sv =====
// Checker for the gripper compliance controller: predicts every result item and compares.
`timescale 1ns / 1ps
module gcc_checker import gcc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gcc_in_if                 i_in,
    gcc_out_if                i_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                o_errors,
    output int                o_pending
);

    localparam longint W_MAX = longint'(SMAX);
    localparam longint W_MIN = longint'(SMIN);
    localparam longint ONE_L = longint'(ONE);
    localparam longint XMAX_L = longint'(XMAX);
    localparam longint LIMIT_L = longint'(LIMIT);

    typedef struct {
        logic [21:0] setpoint;
        logic        running;
        logic [2:0]  status;
        logic [27:0] force_s;
        logic [21:0] opening_s;
        logic [31:0] velocity_s;
        logic [29:0] current_s;
    } t_sample_result;

    t_sample_result results_due[$];

    logic [63:0] regs_q [8];
    longint force_filt, opening_filt, opening_prev, velocity_filt, current_filt;
    longint cmd_opening, cmd_velocity, acc_one, acc_two, acc_three;
    logic   running_q;
    logic [2:0] status_q;

    function automatic longint clip(longint v);
        if (v > W_MAX) return W_MAX;
        if (v < W_MIN) return W_MIN;
        return v;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_from(logic [63:0] m, logic neg);
        logic [63:0] lim;
        lim = neg ? 64'(W_MAX) + 64'd1 : 64'(W_MAX);
        if (m > lim) m = lim;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        logic         neg;
        logic [127:0] p;
        neg = (a < 0) != (b < 0);
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        if ((p[127:64] >> FRAC_BITS) != 0) return neg ? W_MIN : W_MAX;
        return signed_from(p[FRAC_BITS +: 64], neg);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        logic        neg;
        logic [63:0] x, y, q, r, lim;
        neg = (a < 0) != (b < 0);
        x = magnitude(a);
        y = magnitude(b);
        lim = 64'(W_MAX) + 64'd1;
        if (b == 0) return a > 0 ? W_MAX : (a < 0 ? W_MIN : 0);
        q = x / y;
        r = x % y;
        for (int i = 0; i < FRAC_BITS; i++) begin
            if (q > lim) begin
                q = lim + 64'd1;
                break;
            end
            q = q << 1;
            r = r << 1;
            if (r >= y) begin
                r = r - y;
                q = q | 64'd1;
            end
        end
        return signed_from(q, neg);
    endfunction

    function automatic int reg_width(int idx);
        case (idx)
            REG_MODE: return 3;
            REG_FD:   return 27;
            REG_XD:   return 22;
            REG_VD:   return 24;
            REG_T:    return 13;
            default:  return 26;
        endcase
    endfunction

    function automatic longint reg_val(int idx);
        if (idx == REG_VD && regs_q[REG_VD][23]) return longint'(regs_q[REG_VD]) - (64'sd1 <<< 24);
        return longint'(regs_q[idx]);
    endfunction

    function automatic longint blend(longint w1, longint w2, longint fresh, longint old);
        return clip(fx_mul(w1, fresh) + fx_mul(w2, old));
    endfunction

    task automatic regs_to_reset();
        regs_q[REG_MODE] = 0;
        regs_q[REG_FD]   = 0;
        regs_q[REG_XD]   = 64'(XMAX_L);
        regs_q[REG_VD]   = 0;
        regs_q[REG_M]    = 0;
        regs_q[REG_B]    = 0;
        regs_q[REG_K]    = 0;
        regs_q[REG_T]    = 64'(T_RESET);
    endtask

    task automatic clear_integrators();
        cmd_opening  = XMAX_L;
        cmd_velocity = 0;
        acc_one      = 0;
        acc_two      = 0;
        acc_three    = 0;
    endtask

    task automatic halt(logic [2:0] code);
        running_q = 1'b0;
        regs_to_reset();
        clear_integrators();
        status_q = code;
    endtask

    task automatic update_setpoint();
        longint fd, xd, vd, m, b, k, t, fm, mt, kt, den;
        fd = reg_val(REG_FD);
        xd = reg_val(REG_XD);
        vd = reg_val(REG_VD);
        m  = reg_val(REG_M);
        b  = reg_val(REG_B);
        k  = reg_val(REG_K);
        t  = reg_val(REG_T);
        fm = force_filt;
        mt = fx_div(m, t);
        kt = fx_mul(k, t);
        den = clip(clip(mt + kt) + b);
        case (regs_q[REG_MODE][2:0])
            MODE_POS: cmd_opening = xd;
            MODE_ADM: begin
                acc_one = clip(acc_one + cmd_velocity);
                cmd_velocity = fx_div(clip(clip(clip(fd - fm) - fx_mul(kt, acc_one))
                                           + fx_mul(mt, cmd_velocity)), den);
                cmd_opening = clip(cmd_opening + fx_mul(cmd_velocity, t));
            end
            MODE_IMP: begin
                acc_three = clip(acc_three + acc_two);
                acc_two = fx_div(clip(clip(fm - fx_mul(kt, acc_three))
                                      + fx_mul(mt, acc_two)), den);
                acc_one = clip(acc_one + fx_mul(acc_two, t));
                cmd_opening = clip(xd - acc_one);
            end
            MODE_STF: cmd_opening = clip(xd - fx_div(fm, k));
            MODE_DMP: begin
                cmd_velocity = clip(vd - fx_div(fm, b));
                cmd_opening = clip(cmd_opening + fx_mul(cmd_velocity, t));
            end
            MODE_PAR: begin
                acc_one = clip(acc_one + fx_mul(fm, t));
                cmd_velocity = clip(clip(vd - fx_mul(acc_one, k)) - fx_div(fm, b));
                cmd_opening = clip(cmd_opening + fx_mul(cmd_velocity, t));
            end
            default: begin
                halt(ST_BADMODE);
                return;
            end
        endcase
        if (cmd_opening > XMAX_L) cmd_opening = XMAX_L;
        else if (cmd_opening < 0) cmd_opening = 0;
    endtask

    task automatic sample_tick(longint fa, longint fb, longint jaw, longint code);
        longint t, w1, w2, force_mean, cur, vin, mv;
        t = reg_val(REG_T);
        w1 = t * 10;
        if (w1 > ONE_L) w1 = ONE_L;
        w2 = ONE_L - w1;
        force_mean = ((fa + fb) <<< FRAC_BITS) / 2;
        force_filt = blend(w1, w2, force_mean, force_filt);
        opening_filt = blend(w1, w2, jaw, opening_filt);
        vin = fx_div(clip(opening_filt - opening_prev), t);
        velocity_filt = blend(w1, w2, vin, velocity_filt);
        mv = code * 3300 / 4096;
        cur = (mv - 318) * 5 * (ONE_L / 4);
        current_filt = blend(w1, w2, cur, current_filt);
        opening_prev = opening_filt;
        if (force_filt > LIMIT_L) halt(ST_FORCE);
        if (current_filt > LIMIT_L) halt(ST_CURRENT);
        if (running_q) update_setpoint();
    endtask

    function automatic t_sample_result snapshot();
        t_sample_result r;
        r.setpoint   = running_q ? cmd_opening[21:0] : XMAX_L[21:0];
        r.running    = running_q;
        r.status     = status_q;
        r.force_s    = force_filt[27:0];
        r.opening_s  = opening_filt[21:0];
        r.velocity_s = velocity_filt[31:0];
        r.current_s  = current_filt[29:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            o_errors++;
            $display("%0t ns: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_sample_result want;
        if (!i_rst_n) begin
            regs_to_reset();
            force_filt = 0;
            opening_filt = XMAX_L;
            opening_prev = XMAX_L;
            velocity_filt = 0;
            current_filt = 0;
            clear_integrators();
            running_q = 1'b0;
            status_q = ST_OK;
            results_due.delete();
            o_errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                regs_q[paddr[ADDR_W-1:2]] = 64'(pwdata)
                    & ((64'd1 << reg_width(int'(paddr[ADDR_W-1:2]))) - 64'd1);
            end
            if (i_out.valid && i_out.ready) begin
                if (results_due.size() == 0) begin
                    o_errors++;
                    $display("%0t ns: result item with nothing expected", $time);
                end else begin
                    want = results_due.pop_front();
                    check_field("setpoint_opening", 32'(want.setpoint),
                                32'(i_out.setpoint_opening));
                    check_field("running", 32'(want.running), 32'(i_out.running));
                    check_field("status_code", 32'(want.status), 32'(i_out.status_code));
                    check_field("force_smoothed", 32'(want.force_s),
                                32'(i_out.force_smoothed));
                    check_field("opening_smoothed", 32'(want.opening_s),
                                32'(i_out.opening_smoothed));
                    check_field("velocity_smoothed", want.velocity_s,
                                32'(i_out.velocity_smoothed));
                    check_field("current_smoothed", 32'(want.current_s),
                                32'(unsigned'(i_out.current_smoothed)));
                end
            end
            if (i_in.valid && i_in.ready) begin
                case (i_in.func)
                    FUNC_TICK: sample_tick(longint'(i_in.force_a), longint'(i_in.force_b),
                                           longint'(i_in.jaw_opening),
                                           longint'(i_in.current_sample));
                    FUNC_START: begin
                        clear_integrators();
                        running_q = 1'b1;
                        status_q = ST_STARTED;
                    end
                    FUNC_STOP: halt(ST_USER);
                    default: ;
                endcase
                results_due.push_back(snapshot());
            end
        end
        o_pending = results_due.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the gripper compliance controller: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb;
    import gcc_pkg::*;

    localparam int PHASES = 60;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    int errors, pending;
    int send_idle, recv_idle;
    logic pressure_on;
    logic pressure_done;

    gcc_in_if  in_ch ();
    gcc_out_if out_ch ();

    gripper_compliance_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gcc_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off while the sender keeps offering
    initial begin
        int hold;
        hold = 0;
        pressure_done = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (pressure_on && !pressure_done) begin
                hold = 600;
                pressure_done <= 1'b1;
            end
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic send_item(logic [1:0] func, logic [11:0] fa, logic [11:0] fb,
                             logic [21:0] jaw, logic [11:0] code);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.func           <= func;
        in_ch.force_a        <= fa;
        in_ch.force_b        <= fb;
        in_ch.jaw_opening    <= jaw;
        in_ch.current_sample <= code;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(logic [2:0] mode, logic [31:0] fd, logic [31:0] xd,
                             logic [31:0] vd, logic [31:0] m, logic [31:0] b,
                             logic [31:0] k, logic [31:0] t);
        write_reg(REG_MODE, 32'(mode));
        write_reg(REG_FD, fd);
        write_reg(REG_XD, xd);
        write_reg(REG_VD, vd);
        write_reg(REG_M, m);
        write_reg(REG_B, b);
        write_reg(REG_K, k);
        write_reg(REG_T, t);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'd65536000;
            2: return $urandom_range(65536000);
            default: return $urandom_range(655360);
        endcase
    endfunction

    task automatic random_config();
        logic [2:0]  mode;
        logic [31:0] fd, xd, vd, t;
        mode = ($urandom_range(9) == 0) ? (($urandom_range(1) == 1) ? 3'd7 : 3'd0)
                                        : 3'($urandom_range(6, 1));
        case ($urandom_range(3))
            0: fd = 32'd0;
            1: fd = 32'd131072000;
            default: fd = $urandom_range(131072000);
        endcase
        xd = ($urandom_range(4) == 0) ? 32'd3604480 : $urandom_range(3604480);
        case ($urandom_range(4))
            0: vd = 32'(-32'sd6553600) & 32'hFFFFFF;
            1: vd = 32'd6553600;
            default: vd = 32'($urandom_range(13107200)) - 32'd6553600;
        endcase
        case ($urandom_range(5))
            0: t = 32'd66;
            1: t = 32'd6554;
            2: t = 32'd8191;
            default: t = $urandom_range(6554, 66);
        endcase
        write_all(mode, fd, xd, vd, pick_gain(), pick_gain(), pick_gain(), t);
    endtask

    task automatic random_tick();
        logic [11:0] code;
        code = ($urandom_range(19) == 0) ? 12'($urandom_range(4095))
                                         : 12'($urandom_range(2300));
        send_item(FUNC_TICK, 12'($urandom_range(2600)), 12'($urandom_range(2600)),
                  22'($urandom_range(3604480)), code);
    endtask

    task automatic noise_item();
        send_item(2'($urandom_range(3)), 12'($urandom_range(4000)), 12'($urandom_range(4000)),
                  22'($urandom_range(3604480)), 12'($urandom_range(4095)));
    endtask

    initial begin
        int n;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_TICK;
        in_ch.force_a = '0;
        in_ch.force_b = '0;
        in_ch.jaw_opening = '0;
        in_ch.current_sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pressure_on = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        i_rst_n = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: idle items, every mode, limits, division by zero
        send_item(2'd3, 12'd0, 12'd0, 22'd0, 12'd0);
        send_item(FUNC_TICK, 12'd4000, 12'd0, 22'd3604480, 12'd0);
        for (int m = 0; m < 7; m++) begin
            drain();
            write_all(3'(m), 32'd13107200, 32'd1966080, 32'hFF0000, 32'd65536,
                      (m == MODE_DMP) ? 32'd0 : 32'd131072,
                      (m == MODE_STF) ? 32'd0 : 32'd65536,
                      (m % 2 == 0) ? 32'd66 : 32'd6554);
            send_item(FUNC_START, 12'd0, 12'd0, 22'd0, 12'd0);
            send_item(FUNC_TICK, 12'd0, 12'd0, 22'd0, 12'd0);
            send_item(FUNC_TICK, 12'd1000, 12'd1000, 22'd3604480, 12'd2000);
        end
        send_item(FUNC_STOP, 12'd0, 12'd0, 22'd0, 12'd0);
        drain();
        write_all(MODE_POS, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd8191);
        send_item(FUNC_START, 12'd0, 12'd0, 22'd0, 12'd0);
        send_item(FUNC_TICK, 12'd4000, 12'd4000, 22'd0, 12'd0);
        drain();
        write_all(MODE_POS, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd6554);
        send_item(FUNC_START, 12'd0, 12'd0, 22'd0, 12'd0);
        send_item(FUNC_TICK, 12'd0, 12'd0, 22'd0, 12'd4095);
        send_item(2'd3, 12'd4095, 12'd4095, 22'h3FFFFF, 12'd4095);

        // random bursts: start, ticks with random content, sometimes a stop
        for (int p = 0; p < PHASES; p++) begin
            drain();
            if (p < PHASES / 3) begin
                send_idle = 35;
                recv_idle = 61;
            end else if (p < 2 * PHASES / 3) begin
                send_idle = 61;
                recv_idle = 35;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_config();
            pressure_on = (p == PHASES - 5);
            send_item(FUNC_START, 12'd0, 12'd0, 22'd0, 12'd0);
            n = $urandom_range(30, 22);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9) == 0) noise_item();
                else random_tick();
            end
            if ($urandom_range(9) < 3) send_item(FUNC_STOP, 12'd0, 12'd0, 22'd0, 12'd0);
        end

        drain();
        repeat (300) @(negedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
